FILE: hw/rtl/skf_pkg.sv
`default_nettype none

package skf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW   = DataW + 1 + GainW + 1;

  // 1.0 in Q1.16
  localparam logic [GainW-1:0] OneQ16 = 17'h1_0000;

  localparam logic [DataW-1:0] ProcNoiseReset = 32'd327680;
  localparam logic [DataW-1:0] MeasNoiseReset = 32'd65536;
  localparam logic [DataW-1:0] InitEstReset   = 32'd2949120;

  typedef logic [DataW-1:0]   data_t;
  typedef logic [GainW-1:0]   gain_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROC_NOISE = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_INIT_EST   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [DataW-1:0]  dividend;
    logic [DataW:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skf_sample_if.sv
`default_nettype none

interface skf_sample_if;
  import skf_pkg::*;

  logic         valid;
  logic         ready;
  logic signed [DataW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_result_if.sv
`default_nettype none

interface skf_result_if;
  import skf_pkg::*;

  logic         valid;
  logic         ready;
  logic signed [DataW-1:0] filtered;
  logic [GainW-1:0]        gain;

  modport source (output valid, output filtered, output gain, input ready);
  modport sink   (input valid, input filtered, input gain, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/scalar_kalman_filter.sv
`default_nettype none

// Channel   | Dir | Payload                           | Notes
// ----------+-----+-----------------------------------+-------------------------
// in_i      | in  | sample   s32 Q16.16               | one item, one result
// out_o     | out | filtered s32 Q16.16, gain u17 Q1.16 | registered, held on stall
// cfg_*     | in  | cfg_idx_i 2b, cfg_data_i 32b      | write-only, idx 0-2 restart
//
// Each item passes through the sum, divide, two multiply and write-back steps
// from accept to the result showing on out_o, and the next item is accepted only
// after write-back; the 17-step restoring divider that forms the gain sets most of
// that. in_i is ready only while the sequencer is idle. A result waiting on out_o
// holds back only the final write-back of the next item. Reset loads the register
// defaults, the initial estimate and a zero covariance.
module scalar_kalman_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  skf_sample_if.sink              in_i,
  skf_result_if.source            out_o,
  input  wire logic               cfg_we_i,
  input  wire skf_pkg::cfg_idx_t  cfg_idx_i,
  input  wire skf_pkg::data_t     cfg_data_i
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_X,
    ST_MUL_P,
    ST_WB
  } state_e;

  state_e state_q;

  // configuration
  logic [DataW-1:0] pn_q;
  logic [DataW-1:0] mn_q;
  logic [DataW-1:0] ie_q;

  // filter state
  logic [DataW-1:0] est_q;
  logic [DataW-1:0] cov_q;

  // per-item working registers
  logic [DataW-1:0]        sample_q;
  logic [DataW-1:0]        p1_q;
  logic [GainW-1:0]        gain_q;
  logic signed [ProdW-1:0] prod_q;

  // result register
  logic             out_valid_q;
  logic [DataW-1:0] out_filt_q;
  logic [GainW-1:0] out_gain_q;

  logic [DataW:0]          p1_sum;
  logic [DataW-1:0]        p1_sat;
  logic signed [DataW:0]   diff;
  logic signed [DataW:0]   mul_a;
  logic signed [GainW:0]   mul_b;
  logic signed [ProdW-1:0] mul_p;

  div_req_t div_req;
  div_sts_t div_sts;
  gain_t    div_quo;

  // predict: covariance plus process noise, clamped at full scale
  assign p1_sum = {1'b0, cov_q} + {1'b0, pn_q};
  assign p1_sat = p1_sum[DataW] ? '1 : p1_sum[DataW-1:0];

  // gain = p1 / (p1 + R), denominator kept at 33 bits
  assign div_req.start    = (state_q == ST_DIV_START);
  assign div_req.dividend = p1_q;
  assign div_req.divisor  = {1'b0, p1_q} + {1'b0, mn_q};

  skf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  // innovation, exact in 33 bits
  assign diff = $signed({sample_q[DataW-1], sample_q}) - $signed({est_q[DataW-1], est_q});

  // shared multiplier: (z - x) * K, then p1 * (1 - K)
  always_comb begin
    if (state_q == ST_MUL_X) begin
      mul_a = diff;
      mul_b = $signed({1'b0, gain_q});
    end else begin
      mul_a = $signed({1'b0, p1_q});
      mul_b = $signed({1'b0, OneQ16 - gain_q});
    end
  end
  assign mul_p = ProdW'(mul_a * mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pn_q        <= ProcNoiseReset;
      mn_q        <= MeasNoiseReset;
      ie_q        <= InitEstReset;
      est_q       <= InitEstReset;
      cov_q       <= '0;
      sample_q    <= '0;
      p1_q        <= '0;
      gain_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_filt_q  <= '0;
      out_gain_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            sample_q <= in_i.sample;
            state_q  <= ST_SUM;
          end
        end
        ST_SUM: begin
          p1_q    <= p1_sat;
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_sts.done) begin
            gain_q  <= div_quo;
            state_q <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL_P;
        end
        ST_MUL_P: begin
          // floor((z - x) * K / 2^16) is the arithmetic shift, low 32 bits fit
          est_q   <= est_q + prod_q[DataW+15:16];
          prod_q  <= mul_p;
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (!out_valid_q || out_o.ready) begin
            cov_q       <= prod_q[DataW+15:16];
            out_valid_q <= 1'b1;
            out_filt_q  <= est_q;
            out_gain_q  <= gain_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // config writes must arrive only while idle (not enforced here); writes to idx 0-2 restart the filter
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PROC_NOISE: begin
            pn_q  <= cfg_data_i;
            est_q <= ie_q;
            cov_q <= '0;
          end
          CFG_MEAS_NOISE: begin
            mn_q  <= cfg_data_i;
            est_q <= ie_q;
            cov_q <= '0;
          end
          CFG_INIT_EST: begin
            ie_q  <= cfg_data_i;
            est_q <= cfg_data_i;
            cov_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_filt_q;
  assign out_o.gain     = out_gain_q;

  // gain never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.gain <= OneQ16))
    else $error("gain above one");

  // divider runs only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> (state_q == ST_DIV_WAIT))
    else $error("divider busy outside divide step");

  // one item at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready held after accept");

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.filtered)
      && $stable(out_o.gain)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: hw/rtl/skf_div.sv
`default_nettype none

// Restoring divider: quotient = floor(dividend * 2^16 / divisor), one bit a cycle.
// Caller guarantees dividend <= divisor; zero divisor gives zero.
module skf_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire skf_pkg::div_req_t req_i,
  output skf_pkg::div_sts_t      sts_o,
  output skf_pkg::gain_t         quo_o
);
  import skf_pkg::*;

  localparam int unsigned CntW = $clog2(GainW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(GainW);

  logic [DataW:0]   rem_q;
  logic [DataW:0]   divisor_q;
  logic [GainW-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             first_q;
  logic             zero_q;
  logic             done_q;

  logic [DataW+1:0] shifted;
  logic [DataW+1:0] trial;
  logic             ge;

  // first step compares unshifted (quotient bit for 1.0)
  assign shifted = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, divisor_q};
  assign ge      = (shifted >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      divisor_q <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      first_q   <= 1'b0;
      zero_q    <= 1'b0;
      done_q    <= 1'b0;
    end else if (req_i.start) begin
      rem_q     <= {1'b0, req_i.dividend};
      divisor_q <= req_i.divisor;
      quo_q     <= '0;
      cnt_q     <= Steps;
      first_q   <= 1'b1;
      zero_q    <= (req_i.divisor == '0);
      done_q    <= 1'b0;
    end else if (cnt_q != '0) begin
      rem_q   <= ge ? trial[DataW:0] : shifted[DataW:0];
      quo_q   <= {quo_q[GainW-2:0], ge};
      first_q <= 1'b0;
      cnt_q   <= cnt_q - CntW'(1);
      done_q  <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;
  assign quo_o      = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire
